[design/motor_feedback_step_move_controller_top_macros.svh]
// Assertion macros used by the step-move controller checker.
`ifndef MOTOR_FEEDBACK_STEP_MOVE_CONTROLLER_TOP_MACROS_SVH
`define MOTOR_FEEDBACK_STEP_MOVE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MFSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfsm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfsm assertion failed");

`endif

[design/mfsm_pkg.sv]
// Shared constants and types for the motor feedback step-move controller.
package mfsm_pkg;

    // Frame layout
    localparam int FRAME_LEN = 22;
    localparam int BI_W      = $clog2(FRAME_LEN + 1);
    localparam int SPD_IDX   = 5;
    localparam int POS_IDX   = 15;
    localparam int HDR_LEN   = 4;

    localparam logic [7:0] HDR_PAT [HDR_LEN] = '{8'd184, 8'd183, 8'd1, 8'd193};

    // Speed folding
    localparam logic [15:0] SPEED_FOLD_AT = 16'd20000;
    localparam logic [15:0] SPEED_FULL    = 16'hFFFF;
    localparam logic [15:0] RUN_CNT_MAX   = 16'hFFFF;

    // Input operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_FRAMES = 2'd3;

    // Configuration reset values
    localparam logic [14:0] RST_TURN_SPEED    = 15'd130;
    localparam logic [15:0] RST_JUMP_LIMIT    = 16'd500;
    localparam logic [15:0] RST_SPEED_LIMIT   = 16'd3000;
    localparam logic [7:0]  RST_SETTLE_FRAMES = 8'd15;

    // Parser to controller: frame completion and raw fields
    typedef struct packed {
        logic        done;
        logic [31:0] pos_raw;
        logic [15:0] speed_raw;
    } t_frame_info;

endpackage

[design/mfsm_frame_parser.sv]
// Header sync and field capture for the feedback byte stream.
module mfsm_frame_parser
    import mfsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output t_frame_info o_info
);

    logic [2:0]      r_hm, n_hm;
    logic [BI_W-1:0] r_bi, n_bi;
    logic [7:0]      r_pos [4];
    logic [7:0]      r_spd [2];
    logic [7:0]      m_pos [4];
    logic [7:0]      m_spd [2];
    logic            hdr_phase;
    logic            last_byte;

    assign hdr_phase = (r_hm < 3'(HDR_LEN));
    assign last_byte = (r_bi >= BI_W'(FRAME_LEN - 1));

    // Header match and byte index
    always_comb begin
        n_hm = r_hm;
        n_bi = r_bi;
        if (i_en) begin
            if (hdr_phase) begin
                if (i_byte == HDR_PAT[r_hm[1:0]]) begin
                    n_hm = r_hm + 3'd1;
                end else if (i_byte == HDR_PAT[0]) begin
                    n_hm = 3'd1;
                end else begin
                    n_hm = 3'd0;
                end
                n_bi = BI_W'(n_hm);
            end else if (last_byte) begin
                n_hm = 3'd0;
                n_bi = '0;
            end else begin
                n_bi = r_bi + BI_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm <= 3'd0;
            r_bi <= '0;
        end else begin
            r_hm <= n_hm;
            r_bi <= n_bi;
        end
    end

    // Only the speed and position bytes are kept
    always_ff @(posedge i_clk) begin
        if (i_en && !hdr_phase) begin
            for (int k = 0; k < 4; k++) begin
                if (r_bi == BI_W'(POS_IDX + k)) r_pos[k] <= i_byte;
            end
            for (int k = 0; k < 2; k++) begin
                if (r_bi == BI_W'(SPD_IDX + k)) r_spd[k] <= i_byte;
            end
        end
    end

    // Fields as seen with the current byte included
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            m_pos[k] = (!hdr_phase && r_bi == BI_W'(POS_IDX + k)) ? i_byte : r_pos[k];
        end
        for (int k = 0; k < 2; k++) begin
            m_spd[k] = (!hdr_phase && r_bi == BI_W'(SPD_IDX + k)) ? i_byte : r_spd[k];
        end
    end

    assign o_info.done      = i_en && !hdr_phase && last_byte;
    assign o_info.pos_raw   = {m_pos[3], m_pos[2], m_pos[1], m_pos[0]};
    assign o_info.speed_raw = {m_spd[1], m_spd[0]};

endmodule

[design/motor_feedback_step_move_controller_top.sv]
// Top level of the motor feedback step-move controller.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per handshake:
//   op 0 is a feedback byte, op 1 starts a signed step move of i_step_count
//   steps, op 2 marks the current position as reference; op 3 is ignored.
//   Each completed 22-byte frame gives one result item on the output
//   channel (o_out_valid / i_out_stall); other items give none.
//   A frame's last byte passes the input register and one pass of logic,
//   then the result register. Throughput: one item per cycle while no
//   result is stalled, set by the single input register that feeds one
//   pass of frame-check logic into the result register.
//   A stalled result holds; the input register keeps filling until it holds
//   an item that cannot move on, then o_in_stall rises.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) must be made
//   while the block is idle; the block itself does not enforce this.
//   Synchronous active-low reset clears the parser, history, move state and
//   both valid flags, and restores the register defaults.
module motor_feedback_step_move_controller_top
    import mfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_rx_byte,
    input  logic signed [31:0]    i_step_count,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_frame_accepted,
    output logic signed [31:0]    o_position,
    output logic [30:0]           o_relative_position,
    output logic [15:0]           o_speed_magnitude,
    output logic                  o_run_cmd_valid,
    output logic signed [15:0]    o_run_speed,
    output logic                  o_stop_cmd_valid,
    output logic                  o_move_done,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [14:0] r_turn;
    logic [15:0] r_jump;
    logic [15:0] r_spd_lim;
    logic [7:0]  r_settle;

    // input register
    logic               r_a_valid;
    logic [1:0]         r_a_op;
    logic [7:0]         r_a_byte;
    logic signed [31:0] r_a_step;

    // controller state
    logic signed [31:0] r_h0, n_h0, r_h1, n_h1;
    logic [1:0]         r_hc, n_hc;
    logic signed [31:0] r_cur, n_cur, r_ref, n_ref, r_start, n_start, r_target, n_target;
    logic [15:0]        r_rfc, n_rfc;
    logic               r_running, n_running, r_ma, n_ma, r_sv, n_sv;

    // result register
    logic               r_out_valid;
    logic               r_acc;
    logic signed [31:0] r_pos;
    logic [30:0]        r_rel;
    logic [15:0]        r_spd;
    logic               r_run_v;
    logic signed [15:0] r_rspeed;
    logic               r_stop_v;
    logic               r_done;

    logic proceed, fire_b, is_byte;
    t_frame_info info;

    // frame-check intermediates
    logic signed [31:0] p1;
    logic [15:0]        speed;
    logic signed [32:0] sum33, pp33, dist_d, rel_d;
    logic signed [33:0] dev_d, dist34, thr34;
    logic [33:0]        dev_abs;
    logic [32:0]        dist_abs, rel_abs;
    logic [31:0]        tgt_abs;
    logic               hist_full, accepted;
    logic               run_v, stop_v, done;
    logic signed [15:0] rspeed;
    logic [30:0]        rel_sat;

    // handshake
    assign proceed    = !r_out_valid || !i_out_stall;
    assign fire_b     = r_a_valid && proceed;
    assign is_byte    = fire_b && (r_a_op == OP_BYTE);
    assign o_in_stall = r_a_valid && !proceed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn    <= RST_TURN_SPEED;
            r_jump    <= RST_JUMP_LIMIT;
            r_spd_lim <= RST_SPEED_LIMIT;
            r_settle  <= RST_SETTLE_FRAMES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TURN_SPEED:    r_turn    <= i_cfg_data[14:0];
                CFG_JUMP_LIMIT:    r_jump    <= i_cfg_data;
                CFG_SPEED_LIMIT:   r_spd_lim <= i_cfg_data;
                CFG_SETTLE_FRAMES: r_settle  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_a_op   <= i_op;
            r_a_byte <= i_rx_byte;
            r_a_step <= i_step_count;
        end
    end

    mfsm_frame_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (is_byte),
        .i_byte  (r_a_byte),
        .o_info  (info)
    );

    // plausibility check and move control
    always_comb begin
        n_h0      = r_h0;
        n_h1      = r_h1;
        n_hc      = r_hc;
        n_cur     = r_cur;
        n_ref     = r_ref;
        n_start   = r_start;
        n_target  = r_target;
        n_rfc     = r_rfc;
        n_running = r_running;
        n_ma      = r_ma;
        n_sv      = r_sv;
        run_v     = 1'b0;
        stop_v    = 1'b0;
        done      = 1'b0;
        rspeed    = 16'sd0;

        p1    = signed'(info.pos_raw);
        speed = (info.speed_raw > SPEED_FOLD_AT) ? (SPEED_FULL - info.speed_raw)
                                                 : info.speed_raw;

        // midpoint of newest and oldest, truncated toward zero
        sum33   = {p1[31], p1} + {r_h1[31], r_h1};
        pp33    = signed'(sum33 + {32'd0, sum33[32]}) >>> 1;
        dev_d   = {pp33[32], pp33} - {{2{r_h0[31]}}, r_h0};
        dev_abs = dev_d[33] ? unsigned'(-dev_d) : unsigned'(dev_d);

        hist_full = (r_hc == 2'd2);
        accepted  = !hist_full ||
                    ((dev_abs < {18'd0, r_jump}) && (speed < r_spd_lim));

        // start of a move
        if (fire_b && r_a_op == OP_START) begin
            n_target  = r_a_step;
            n_ma      = 1'b1;
            n_running = 1'b1;
            n_rfc     = 16'd0;
            n_sv      = 1'b0;
            n_start   = 32'sd0;
        end

        // reference mark
        if (fire_b && r_a_op == OP_MARK) begin
            n_ref = r_cur;
        end

        // history update
        if (info.done) begin
            if (hist_full) begin
                if (accepted) begin
                    n_cur = r_h1;
                    n_h1  = r_h0;
                    n_h0  = p1;
                end else begin
                    n_hc = 2'd0;
                end
            end else begin
                n_h1 = r_h0;
                n_h0 = p1;
                n_hc = r_hc + 2'd1;
            end
        end

        // run command and start capture
        if (info.done && accepted && r_running) begin
            if (!r_sv) begin
                n_start = n_cur;
                n_sv    = 1'b1;
            end
            rspeed = r_target[31] ? -signed'({1'b0, r_turn}) : signed'({1'b0, r_turn});
            if (r_rfc < RUN_CNT_MAX) n_rfc = r_rfc + 16'd1;
            run_v = 1'b1;
        end

        // travel reached check
        dist_d   = {n_start[31], n_start} - {n_cur[31], n_cur};
        dist_abs = dist_d[32] ? unsigned'(-dist_d) : unsigned'(dist_d);
        dist34   = signed'({1'b0, dist_abs});
        tgt_abs  = r_target[31] ? unsigned'(-r_target) : unsigned'(r_target);
        thr34    = signed'({2'b00, tgt_abs}) - 34'sd1;
        if (info.done && accepted && r_ma && n_sv) begin
            if (dist34 >= thr34 && n_rfc > {8'd0, r_settle}) begin
                n_running = 1'b0;
                if (speed != 16'd0) begin
                    stop_v = 1'b1;
                end else begin
                    n_rfc = 16'd0;
                    n_ma  = 1'b0;
                    done  = 1'b1;
                end
            end
        end

        // distance from reference, saturated
        rel_d   = {n_cur[31], n_cur} - {n_ref[31], n_ref};
        rel_abs = rel_d[32] ? unsigned'(-rel_d) : unsigned'(rel_d);
        rel_sat = (|rel_abs[32:31]) ? 31'h7FFF_FFFF : rel_abs[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0      <= 32'sd0;
            r_h1      <= 32'sd0;
            r_hc      <= 2'd0;
            r_cur     <= 32'sd0;
            r_ref     <= 32'sd0;
            r_start   <= 32'sd0;
            r_target  <= 32'sd0;
            r_rfc     <= 16'd0;
            r_running <= 1'b0;
            r_ma      <= 1'b0;
            r_sv      <= 1'b0;
        end else begin
            r_h0      <= n_h0;
            r_h1      <= n_h1;
            r_hc      <= n_hc;
            r_cur     <= n_cur;
            r_ref     <= n_ref;
            r_start   <= n_start;
            r_target  <= n_target;
            r_rfc     <= n_rfc;
            r_running <= n_running;
            r_ma      <= n_ma;
            r_sv      <= n_sv;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= info.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (info.done) begin
            r_acc    <= accepted;
            r_pos    <= n_cur;
            r_rel    <= rel_sat;
            r_spd    <= speed;
            r_run_v  <= run_v;
            r_rspeed <= rspeed;
            r_stop_v <= stop_v;
            r_done   <= done;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_accepted    = r_acc;
    assign o_position          = r_pos;
    assign o_relative_position = r_rel;
    assign o_speed_magnitude   = r_spd;
    assign o_run_cmd_valid     = r_run_v;
    assign o_run_speed         = r_rspeed;
    assign o_stop_cmd_valid    = r_stop_v;
    assign o_move_done         = r_done;

endmodule

[design/mfsm_checker.sv]
// Port-level checker for the step-move controller and its bind.
`include "motor_feedback_step_move_controller_top_macros.svh"

module mfsm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_frame_accepted,
    input logic [15:0]        o_speed_magnitude,
    input logic               o_run_cmd_valid,
    input logic signed [15:0] o_run_speed,
    input logic               o_stop_cmd_valid,
    input logic               o_move_done
);

    // a stalled result stays offered
    `MFSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // no run command means zero run speed
    `MFSM_ASSERT_NOW(a_run_speed_zero, i_clk, i_rst_n, o_out_valid && !o_run_cmd_valid, o_run_speed == 16'sd0)

    // done only at standstill, never together with a stop
    `MFSM_ASSERT_NOW(a_done_still, i_clk, i_rst_n, o_out_valid && o_move_done, o_speed_magnitude == 16'd0 && !o_stop_cmd_valid)

    // a rejected frame issues nothing
    `MFSM_ASSERT_NOW(a_reject_quiet, i_clk, i_rst_n, o_out_valid && !o_frame_accepted, !o_run_cmd_valid && !o_stop_cmd_valid && !o_move_done)

endmodule

bind motor_feedback_step_move_controller_top mfsm_checker u_mfsm_checker (.*);
